[design/pcmcd_pkg.sv]
package pcmcd_pkg;

	// channel limit of one frame
	localparam int MAX_CHANNELS = 8;

	// configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_FORMAT   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = CFG_IDX_W'(1);

	// sample format codes; the two unused codes behave as s16
	typedef enum logic [2:0] {
		FMT_U8  = 3'd0,
		FMT_S16 = 3'd1,
		FMT_S24 = 3'd2,
		FMT_S32 = 3'd3,
		FMT_F32 = 3'd4,
		FMT_F64 = 3'd5
	} fmt_t;

	localparam logic [3:0] CHN_RESET = 4'd2;

	// channel handling of a frame
	typedef enum logic [1:0] {
		MODE_MONO,
		MODE_STEREO,
		MODE_DOWNMIX
	} mode_t;

	// pipeline depth: converter stages, then downmix stages
	localparam int CONV_STG = 3;
	localparam int MIX_STG  = 4;
	localparam int NSTG     = CONV_STG + MIX_STG;

	typedef struct packed {
		logic [MIX_STG-1:0]  mix;
		logic [CONV_STG-1:0] conv;
	} pipe_en_t;

	// float to fixed: mantissa with hidden bit, integer part below 2^31
	localparam int MANT_W = 53;
	localparam int MAG_W  = 31;
	localparam int SHW    = MANT_W + MAG_W;
	localparam int RSH_W  = $clog2(SHW);
	// right shift of {mant, 31 zeros} is BASE minus the biased exponent
	localparam logic [11:0] F32_BASE = 12'd166;
	localparam logic [11:0] F64_BASE = 12'd1091;

	// downmix gains
	localparam logic signed [14:0] C_GAIN  = 15'sd5818;
	localparam int                 C_SHIFT = 13;
	localparam logic signed [14:0] S_GAIN  = 15'sd5248;
	localparam int                 S_SHIFT = 14;

endpackage

[design/pcmcd_if.sv]
interface pcmcd_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] sample0;
	logic [63:0] sample1;
	logic [63:0] sample2;
	logic [63:0] sample3;
	logic [63:0] sample4;
	logic [63:0] sample5;
	logic [63:0] sample6;
	logic [63:0] sample7;

	modport source (output valid, sample0, sample1, sample2, sample3,
		sample4, sample5, sample6, sample7, input ready);
	modport sink (input valid, sample0, sample1, sample2, sample3,
		sample4, sample5, sample6, sample7, output ready);
endinterface

interface pcmcd_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] out_first;
	logic signed [15:0] out_second;
	logic [1:0]         out_count;

	modport source (output valid, out_first, out_second, out_count, input ready);
	modport sink (input valid, out_first, out_second, out_count, output ready);
endinterface

interface pcmcd_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[design/pcmcd_ctl.sv]
module pcmcd_ctl
	import pcmcd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output pipe_en_t en
);

	logic [NSTG-1:0] v_q;
	logic [NSTG-1:0] v_nxt;
	logic [NSTG:0]   rdy;

	// a stage loads when it is empty or its content moves on
	always_comb begin
		rdy[NSTG] = out_ready;
		for (int k = NSTG - 1; k >= 0; k--) begin
			rdy[k] = !v_q[k] || rdy[k+1];
		end
	end

	assign v_nxt     = {v_q[NSTG-2:0], in_valid};
	assign in_ready  = rdy[0];
	assign out_valid = v_q[NSTG-1];
	assign en        = pipe_en_t'(rdy[NSTG-1:0]);

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 0; k < NSTG; k++) begin
				if (rdy[k]) begin
					v_q[k] <= v_nxt[k];
				end
			end
		end
	end

endmodule

[design/pcmcd_conv.sv]
module pcmcd_conv
	import pcmcd_pkg::*;
(
	input  logic               clk,
	input  pipe_en_t           en,
	input  fmt_t               fmt,
	input  logic [63:0]        raw,
	output logic signed [15:0] res
);

	// stage 1 decode
	logic              is_flt;
	logic [15:0]       int_v;
	logic [10:0]       e_f;
	logic [10:0]       e_eff;
	logic [51:0]       man_f;
	logic [MANT_W-1:0] mant;
	logic [11:0]       base;
	logic              is_max;
	logic              sgn;
	logic [12:0]       r;

	logic              is_flt_s1;
	logic [15:0]       int_s1;
	logic              sgn_s1;
	logic              nan_s1;
	logic              sat_s1;
	logic              zero_s1;
	logic [RSH_W-1:0]  rsh_s1;
	logic [MANT_W-1:0] m_s1;

	logic [SHW-1:0]    shifted;
	logic              is_flt_s2;
	logic [15:0]       int_s2;
	logic              sgn_s2;
	logic              nan_s2;
	logic              ovf_s2;
	logic [15:0]       low_s2;

	logic [15:0]       res_s3;

	// integer formats and float field split
	always_comb begin
		is_flt = 1'b0;
		case (fmt)
			FMT_U8:  int_v = {~raw[7], raw[6:0], 8'h00};
			FMT_S24: int_v = raw[23:8];
			FMT_S32: int_v = raw[31:16];
			FMT_F32: begin
				int_v  = raw[15:0];
				is_flt = 1'b1;
			end
			FMT_F64: begin
				int_v  = raw[15:0];
				is_flt = 1'b1;
			end
			default: int_v = raw[15:0];
		endcase

		// mantissa with the hidden bit just above the fraction field
		if (fmt == FMT_F64) begin
			sgn    = raw[63];
			e_f    = raw[62:52];
			man_f  = raw[51:0];
			mant   = {raw[62:52] != '0, raw[51:0]};
			is_max = &raw[62:52];
			base   = F64_BASE;
		end else begin
			sgn    = raw[31];
			e_f    = {3'b000, raw[30:23]};
			man_f  = {29'd0, raw[22:0]};
			mant   = {29'd0, raw[30:23] != '0, raw[22:0]};
			is_max = &raw[30:23];
			base   = F32_BASE;
		end
		e_eff = (e_f == '0) ? 11'd1 : e_f;
		r     = {1'b0, base} - {2'b00, e_eff};
	end

	always_ff @(posedge clk) begin
		if (en.conv[0]) begin
			is_flt_s1 <= is_flt;
			int_s1    <= int_v;
			sgn_s1    <= sgn;
			nan_s1    <= is_max && (man_f != '0);
			// infinity, or integer part certainly at or above 2^31
			sat_s1    <= is_max || r[12] || (r == '0);
			zero_s1   <= !is_max && !r[12] && (r >= 13'(SHW));
			rsh_s1    <= r[RSH_W-1:0];
			m_s1      <= mant;
		end
	end

	// stage 2 alignment shift and overflow detect
	assign shifted = {m_s1, MAG_W'(0)} >> rsh_s1;

	always_ff @(posedge clk) begin
		if (en.conv[1]) begin
			is_flt_s2 <= is_flt_s1;
			int_s2    <= int_s1;
			sgn_s2    <= sgn_s1;
			nan_s2    <= nan_s1;
			ovf_s2    <= sat_s1 || (!zero_s1 && (shifted[SHW-1:MAG_W] != '0));
			low_s2    <= zero_s1 ? 16'h0000 : shifted[15:0];
		end
	end

	// stage 3 sign, saturation and low half of the int32 result
	always_ff @(posedge clk) begin
		if (en.conv[2]) begin
			if (!is_flt_s2) begin
				res_s3 <= int_s2;
			end else if (nan_s2) begin
				res_s3 <= 16'h0000;
			end else if (ovf_s2) begin
				res_s3 <= sgn_s2 ? 16'h0000 : 16'hffff;
			end else begin
				res_s3 <= sgn_s2 ? (16'h0000 - low_s2) : low_s2;
			end
		end
	end

	assign res = $signed(res_s3);

endmodule

[design/pcmcd_mix.sv]
module pcmcd_mix
	import pcmcd_pkg::*;
(
	input  logic               clk,
	input  pipe_en_t           en,
	input  mode_t              mode,
	input  logic signed [15:0] f0,
	input  logic signed [15:0] f1,
	input  logic signed [15:0] ctr,
	input  logic signed [15:0] ls,
	input  logic signed [15:0] rs,
	output logic signed [15:0] out_first,
	output logic signed [15:0] out_second,
	output logic [1:0]         out_count
);

	localparam logic signed [29:0] C_RND = 30'sd1 <<< C_SHIFT;
	localparam logic signed [31:0] S_RND = 32'sd1 <<< S_SHIFT;

	logic signed [29:0] pc_s4, pl_s4, pr_s4;
	logic signed [15:0] a0_s4, a1_s4;

	logic signed [29:0] tc, tl, tr;
	logic signed [15:0] dc, dl, dr;
	logic signed [17:0] suml_s5, sumr_s5;
	logic signed [15:0] a0_s5, a1_s5;

	logic signed [31:0] ml_s6, mr_s6;
	logic signed [15:0] a0_s6, a1_s6;

	logic signed [31:0] ul, ur;
	logic signed [17:0] ql, qr;
	logic signed [15:0] cl, cr;

	logic signed [15:0] first_s7, second_s7;
	logic [1:0]         count_s7;

	// centre and surround gain products
	always_ff @(posedge clk) begin
		if (en.mix[0]) begin
			pc_s4 <= 30'(ctr) * 30'(C_GAIN);
			pl_s4 <= 30'(ls) * 30'(C_GAIN);
			pr_s4 <= 30'(rs) * 30'(C_GAIN);
			a0_s4 <= f0;
			a1_s4 <= f1;
		end
	end

	// divide toward zero, then side sums
	always_comb begin
		tc = pc_s4 + (pc_s4[29] ? C_RND - 30'sd1 : 30'sd0);
		tl = pl_s4 + (pl_s4[29] ? C_RND - 30'sd1 : 30'sd0);
		tr = pr_s4 + (pr_s4[29] ? C_RND - 30'sd1 : 30'sd0);
		dc = 16'(tc >>> C_SHIFT);
		dl = 16'(tl >>> C_SHIFT);
		dr = 16'(tr >>> C_SHIFT);
	end

	always_ff @(posedge clk) begin
		if (en.mix[1]) begin
			suml_s5 <= 18'(a0_s4) + 18'(dc) + 18'(dl);
			sumr_s5 <= 18'(a1_s4) + 18'(dc) + 18'(dr);
			a0_s5   <= a0_s4;
			a1_s5   <= a1_s4;
		end
	end

	// side gain products
	always_ff @(posedge clk) begin
		if (en.mix[2]) begin
			ml_s6 <= 32'(suml_s5) * 32'(S_GAIN);
			mr_s6 <= 32'(sumr_s5) * 32'(S_GAIN);
			a0_s6 <= a0_s5;
			a1_s6 <= a1_s5;
		end
	end

	// divide toward zero and clip to 16 bits
	always_comb begin
		ul = ml_s6 + (ml_s6[31] ? S_RND - 32'sd1 : 32'sd0);
		ur = mr_s6 + (mr_s6[31] ? S_RND - 32'sd1 : 32'sd0);
		ql = 18'(ul >>> S_SHIFT);
		qr = 18'(ur >>> S_SHIFT);
		if (ql > 18'sd32767) begin
			cl = 16'sh7fff;
		end else if (ql < -18'sd32768) begin
			cl = -16'sh8000;
		end else begin
			cl = 16'(ql);
		end
		if (qr > 18'sd32767) begin
			cr = 16'sh7fff;
		end else if (qr < -18'sd32768) begin
			cr = -16'sh8000;
		end else begin
			cr = 16'(qr);
		end
	end

	// output register, select by channel mode
	always_ff @(posedge clk) begin
		if (en.mix[3]) begin
			case (mode)
				MODE_DOWNMIX: begin
					first_s7  <= cl;
					second_s7 <= cr;
					count_s7  <= 2'd2;
				end
				MODE_MONO: begin
					first_s7  <= a0_s6;
					second_s7 <= 16'sd0;
					count_s7  <= 2'd1;
				end
				default: begin
					first_s7  <= a0_s6;
					second_s7 <= a1_s6;
					count_s7  <= 2'd2;
				end
			endcase
		end
	end

	assign out_first  = first_s7;
	assign out_second = second_s7;
	assign out_count  = count_s7;

endmodule

[design/pcm_sample_convert_downmix_top.sv]
// PCM frame converter with 5.1-to-stereo downmix.
// in_ch carries one frame of eight raw 64-bit channel samples per transfer;
// out_ch carries one result per frame: out_first, out_second, out_count.
// cfg writes register 0 (sample format) or 1 (channel count); cfg.ready is
// always high. The user must write only while no frame is in flight; the
// block does not enforce it. Each used sample is brought to signed 16 bits
// (u8, s16, s24, s32, float32, float64), then mono and stereo pass, six
// channels are downmixed, and other counts keep channels 0 and 1.
// An input transfer reaches out_ch through three converter stages (field
// decode, alignment shift, sign and saturation) and four downmix stages
// (gain multiply, divide and sum, gain multiply, divide, clip and output
// register).
// Throughput is one frame per cycle while not stalled (one frame per stage).
// When out_ch stalls the result holds, frames behind it close up into empty
// stages, and in_ch.ready drops only once all seven stages are full.
// Reset empties the pipeline and sets s16 format and two channels.
module pcm_sample_convert_downmix_top
	import pcmcd_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	pcmcd_in_if.sink        in_ch,
	pcmcd_out_if.source     out_ch,
	pcmcd_cfg_if.sink       cfg
);

	fmt_t               fmt_q;
	logic [3:0]         chn_q;
	logic [3:0]         chn_sat;
	mode_t              mode;
	pipe_en_t           en;
	logic signed [15:0] cv0, cv1, cv2, cv4, cv5;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_S16;
			chn_q <= CHN_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_FORMAT:   fmt_q <= fmt_t'(cfg.data[2:0]);
				REG_CHANNELS: chn_q <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

	// channel mode from the saturated channel count
	assign chn_sat = (chn_q > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : chn_q;

	always_comb begin
		case (chn_sat) inside
			[4'd0:4'd1]: mode = MODE_MONO;
			4'd6:        mode = MODE_DOWNMIX;
			default:     mode = MODE_STEREO;
		endcase
	end

	// pipeline valid and stall control
	pcmcd_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.en        (en)
	);

	// per-channel conversion lanes; LFE and channels 6, 7 are never used
	pcmcd_conv u_conv0 (.clk(clk), .en(en), .fmt(fmt_q), .raw(in_ch.sample0), .res(cv0));
	pcmcd_conv u_conv1 (.clk(clk), .en(en), .fmt(fmt_q), .raw(in_ch.sample1), .res(cv1));
	pcmcd_conv u_conv2 (.clk(clk), .en(en), .fmt(fmt_q), .raw(in_ch.sample2), .res(cv2));
	pcmcd_conv u_conv4 (.clk(clk), .en(en), .fmt(fmt_q), .raw(in_ch.sample4), .res(cv4));
	pcmcd_conv u_conv5 (.clk(clk), .en(en), .fmt(fmt_q), .raw(in_ch.sample5), .res(cv5));

	// downmix and output register
	pcmcd_mix u_mix (
		.clk        (clk),
		.en         (en),
		.mode       (mode),
		.f0         (cv0),
		.f1         (cv1),
		.ctr        (cv2),
		.ls         (cv4),
		.rs         (cv5),
		.out_first  (out_ch.out_first),
		.out_second (out_ch.out_second),
		.out_count  (out_ch.out_count)
	);

endmodule
